[rtl/core/dcfsd_pkg.sv]
// ----------------------------------------------------------------------------
// dcfsd_pkg
// Shared widths, register indexes and side-data types of the fan motor
// speed derivative core.
// ----------------------------------------------------------------------------
`default_nettype none

package dcfsd_pkg;

   localparam int unsigned REG_W    = 32;  // config registers, input fields
   localparam int unsigned DIV_W    = 32;  // divisor and partial remainder
   localparam int unsigned ROOT_W   = 24;  // floor(sqrt(U << 16))
   localparam int unsigned FLUX_W   = 40;
   localparam int unsigned EMF_W    = 56;
   localparam int unsigned SQ_W     = 47;  // (speed * speed) >> 16
   localparam int unsigned DRAG_W   = 62;
   localparam int unsigned DIFF_W   = 57;
   localparam int unsigned CUR_W    = 73;  // quotient bits of the current divide
   localparam int unsigned TORQ_W   = 97;
   localparam int unsigned NET_W    = 98;
   localparam int unsigned RATE_W   = 32;  // quotient bits of the final divide
   localparam int unsigned CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FLUX_GAIN      = 2'd0,
      REG_WINDING_RES    = 2'd1,
      REG_DRAG_COEF      = 2'd2,
      REG_ROTOR_INERTIA  = 2'd3
   } reg_index_type;

   // carried alongside the current division
   typedef struct packed {
      logic [FLUX_W-1:0] flux;
      logic [DRAG_W-1:0] drag;
      logic              speed_neg;
      logic              diff_neg;
   } cur_side_type;

   // carried alongside the final division
   typedef struct packed {
      logic overflow;
      logic neg;
   } rate_side_type;

endpackage

`default_nettype wire

[rtl/core/dc_motor_fan_speed_derivative_core.sv]
// ----------------------------------------------------------------------------
// dc_motor_fan_speed_derivative_core
// Rotor acceleration of a fan motor with square-root flux and quadratic drag,
// Q16.16 fixed point, saturated result.
// ----------------------------------------------------------------------------
//  channel   | dir | beat contents
//  req_*     | in  | tdata: supply_voltage[31:0], rotor_speed[63:32]
//  rsp_*     | out | tdata: speed_rate[31:0]; tuser: saturated
//  csr_*     | in  | write only, index 0..3, 32-bit data
//
//  One beat per cycle in, one per cycle out unless the output stalls; the
//  pipeline has 24 square-root stages, 73 stages of the current divide,
//  32 final-divide stages, plus 9 multiply/add stages and the output register.
//  Reset clears the valid bits and loads the register defaults.
//  A stalled output freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module dc_motor_fan_speed_derivative_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [63:0]                     req_tdata,  // supply_voltage, rotor_speed
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,  // speed_rate
   output logic                            rsp_tuser,  // saturated
   input  logic                            csr_wen,
   input  logic [dcfsd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dcfsd_pkg::REG_W-1:0]     csr_wdata
);
   import dcfsd_pkg::*;

   logic adv;

   // ---------------- configuration ----------------
   logic [REG_W-1:0] flux_gain_ff, wind_res_ff, drag_coef_ff, inertia_ff;
   logic [DIV_W-1:0] res_div, inr_div;

   always_ff @(posedge clock) begin
      if (reset) begin
         flux_gain_ff <= '0;
         wind_res_ff  <= 32'h0001_0000;
         drag_coef_ff <= '0;
         inertia_ff   <= 32'h0001_0000;
      end else if (csr_wen) begin
         unique case (reg_index_type'(csr_index))
            REG_FLUX_GAIN:     flux_gain_ff <= csr_wdata;
            REG_WINDING_RES:   wind_res_ff  <= csr_wdata;
            REG_DRAG_COEF:     drag_coef_ff <= csr_wdata;
            REG_ROTOR_INERTIA: inertia_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // zero divisor acts as the smallest raw value
   assign res_div = (wind_res_ff == '0) ? 32'd1 : wind_res_ff;
   assign inr_div = (inertia_ff == '0) ? 32'd1 : inertia_ff;

   // ---------------- square root, two radicand bits a stage ----------------
   logic              sq_vld_ff  [ROOT_W];
   logic [25:0]       sq_rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] sq_root_ff [ROOT_W];
   logic [31:0]       sq_volt_ff [ROOT_W];
   logic [31:0]       sq_spd_ff  [ROOT_W];
   logic              sq_neg_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      logic              vld_prev, neg_prev, ge;
      logic [25:0]       rem_prev, rem_in;
      logic [ROOT_W-1:0] root_prev;
      logic [31:0]       volt_prev, spd_prev;
      logic [1:0]        pair;
      logic [27:0]       rem_w;
      logic [27:0]       trial;

      if (k == 0) begin : g_first
         assign vld_prev  = req_tvalid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign volt_prev = req_tdata[31:0];
         assign neg_prev  = req_tdata[63];
         assign spd_prev  = req_tdata[63] ? 32'(-req_tdata[63:32]) : req_tdata[63:32];
      end else begin : g_rest
         assign vld_prev  = sq_vld_ff[k-1];
         assign rem_prev  = sq_rem_ff[k-1];
         assign root_prev = sq_root_ff[k-1];
         assign volt_prev = sq_volt_ff[k-1];
         assign neg_prev  = sq_neg_ff[k-1];
         assign spd_prev  = sq_spd_ff[k-1];
      end

      // radicand is the voltage followed by sixteen zero bits
      if (k < 16) begin : g_bits
         assign pair = volt_prev[31-2*k -: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      assign rem_w  = {rem_prev, pair};
      assign trial  = {2'b00, root_prev, 2'b01};
      assign ge     = rem_w >= trial;
      assign rem_in = ge ? 26'(rem_w - trial) : rem_w[25:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[k]  <= rem_in;
            sq_root_ff[k] <= {root_prev[ROOT_W-2:0], ge};
            sq_volt_ff[k] <= volt_prev;
            sq_spd_ff[k]  <= spd_prev;
            sq_neg_ff[k]  <= neg_prev;
         end
      end
   end

   // ---------------- P1: flux and speed-square products ----------------
   logic        p1_vld_ff, p1_neg_ff;
   logic [55:0] p1_fprod_ff;
   logic [63:0] p1_sqprod_ff;
   logic [31:0] p1_volt_ff, p1_spd_ff;

   // ---------------- P2: back-EMF and drag partial products ----------------
   logic              p2_vld_ff, p2_neg_ff;
   logic [FLUX_W-1:0] p2_flux_ff;
   logic [63:0]       p2_elo_ff, p2_dlo_ff;
   logic [39:0]       p2_ehi_ff;
   logic [46:0]       p2_dhi_ff;
   logic [31:0]       p2_volt_ff;
   logic [FLUX_W-1:0] p2_flux_in;
   logic [SQ_W-1:0]   p2_sq_in;

   // ---------------- P3: sums ----------------
   logic              p3_vld_ff, p3_neg_ff;
   logic [EMF_W-1:0]  p3_emf_ff;
   logic [DRAG_W-1:0] p3_drag_ff;
   logic [FLUX_W-1:0] p3_flux_ff;
   logic [31:0]       p3_volt_ff;
   logic [71:0]       p3_emf_in;
   logic [78:0]       p3_drag_in;

   // ---------------- P4: voltage minus back-EMF ----------------
   logic              p4_vld_ff, p4_neg_ff, p4_dneg_ff;
   logic [DIFF_W-1:0] p4_diff_ff;
   logic [DRAG_W-1:0] p4_drag_ff;
   logic [FLUX_W-1:0] p4_flux_ff;
   logic [DIFF_W-1:0] p4_diff_in;
   logic              p4_dneg_in;
   logic              emf_neg;

   assign p2_flux_in = p1_fprod_ff[55:16];
   assign p2_sq_in   = p1_sqprod_ff[62:16];
   assign p3_emf_in  = 72'(p2_elo_ff) + {p2_ehi_ff, 32'b0};
   assign p3_drag_in = 79'(p2_dlo_ff) + {p2_dhi_ff, 32'b0};
   assign emf_neg    = p3_neg_ff && (p3_emf_ff != '0);

   always_comb begin
      if (emf_neg) begin
         p4_diff_in = DIFF_W'(p3_volt_ff) + DIFF_W'(p3_emf_ff);
         p4_dneg_in = 1'b0;
      end else if (EMF_W'(p3_volt_ff) >= p3_emf_ff) begin
         p4_diff_in = DIFF_W'(EMF_W'(p3_volt_ff) - p3_emf_ff);
         p4_dneg_in = 1'b0;
      end else begin
         p4_diff_in = DIFF_W'(p3_emf_ff - EMF_W'(p3_volt_ff));
         p4_dneg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff <= sq_vld_ff[ROOT_W-1];
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_fprod_ff  <= 56'(flux_gain_ff) * 56'(sq_root_ff[ROOT_W-1]);
         p1_sqprod_ff <= 64'(sq_spd_ff[ROOT_W-1]) * 64'(sq_spd_ff[ROOT_W-1]);
         p1_volt_ff   <= sq_volt_ff[ROOT_W-1];
         p1_spd_ff    <= sq_spd_ff[ROOT_W-1];
         p1_neg_ff    <= sq_neg_ff[ROOT_W-1];

         p2_elo_ff  <= 64'(p1_spd_ff) * 64'(p2_flux_in[31:0]);
         p2_ehi_ff  <= 40'(p1_spd_ff) * 40'(p2_flux_in[39:32]);
         p2_dlo_ff  <= 64'(drag_coef_ff) * 64'(p2_sq_in[31:0]);
         p2_dhi_ff  <= 47'(drag_coef_ff) * 47'(p2_sq_in[46:32]);
         p2_flux_ff <= p2_flux_in;
         p2_volt_ff <= p1_volt_ff;
         p2_neg_ff  <= p1_neg_ff;

         p3_emf_ff  <= p3_emf_in[71:16];
         p3_drag_ff <= p3_drag_in[77:16];
         p3_flux_ff <= p2_flux_ff;
         p3_volt_ff <= p2_volt_ff;
         p3_neg_ff  <= p2_neg_ff;

         p4_diff_ff <= p4_diff_in;
         p4_dneg_ff <= p4_dneg_in;
         p4_drag_ff <= p3_drag_ff;
         p4_flux_ff <= p3_flux_ff;
         p4_neg_ff  <= p3_neg_ff;
      end
   end

   // ---------------- current = (diff << 16) / R ----------------
   cur_side_type     cur_side_in, cur_side_out;
   logic             cur_vld;
   logic [CUR_W-1:0] cur_quo;

   assign cur_side_in = '{flux: p4_flux_ff, drag: p4_drag_ff,
                          speed_neg: p4_neg_ff, diff_neg: p4_dneg_ff};

   dcfsd_div #(
      .QW (CUR_W),
      .SW ($bits(cur_side_type))
   ) u_cur_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (p4_vld_ff),
      .in_rem    ('0),
      .in_num    ({p4_diff_ff, 16'b0}),
      .in_side   (cur_side_in),
      .divisor   (res_div),
      .out_valid (cur_vld),
      .out_quo   (cur_quo),
      .out_side  (cur_side_out)
   );

   // ---------------- T1..T3: torque = (current * flux) >> 16 ----------------
   logic              t1_vld_ff, t2_vld_ff, t3_vld_ff, t4_vld_ff, t5_vld_ff;
   logic [63:0]       t1_p00_ff, t1_p10_ff;
   logic [39:0]       t1_p01_ff, t1_p11_ff;
   logic [40:0]       t1_p20_ff;
   logic [16:0]       t1_p21_ff;
   logic [71:0]       t2_r0_ff, t2_r1_ff;
   logic [48:0]       t2_r2_ff;
   logic [112:0]      t3_full_in;
   logic [TORQ_W-1:0] t3_torq_ff;
   logic [DRAG_W-1:0] t1_drag_ff, t2_drag_ff, t3_drag_ff;
   logic              t1_sneg_ff, t2_sneg_ff, t3_sneg_ff;
   logic              t1_dneg_ff, t2_dneg_ff, t3_dneg_ff;

   assign t3_full_in = 113'(t2_r0_ff) + {9'b0, t2_r1_ff, 32'b0} + {t2_r2_ff, 64'b0};

   // ---------------- T4: net = torque - drag ----------------
   logic             torq_neg, drag_neg, net_sign;
   logic [NET_W-1:0] net_mag_in;
   logic [NET_W-1:0] t4_net_ff;
   logic             t4_neg_ff;

   assign torq_neg = t3_dneg_ff && (t3_torq_ff != '0);
   assign drag_neg = t3_sneg_ff && (t3_drag_ff != '0);

   always_comb begin
      if (torq_neg != drag_neg) begin
         net_mag_in = NET_W'(t3_torq_ff) + NET_W'(t3_drag_ff);
         net_sign   = torq_neg;
      end else if (TORQ_W'(t3_drag_ff) <= t3_torq_ff) begin
         net_mag_in = NET_W'(t3_torq_ff - TORQ_W'(t3_drag_ff));
         net_sign   = torq_neg;
      end else begin
         net_mag_in = NET_W'(TORQ_W'(t3_drag_ff) - t3_torq_ff);
         net_sign   = !drag_neg;
      end
   end

   // ---------------- T5: overflow test and divide setup ----------------
   logic             t5_ovf_ff, t5_neg_ff;
   logic [DIV_W-1:0] t5_rem_ff;
   logic [15:0]      t5_low_ff;
   logic             ovf_in;

   // quotient reaches 2^32 exactly when (net << 16) >> 32 >= J
   assign ovf_in = t4_net_ff[NET_W-1:16] >= (NET_W-16)'(inr_div);

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_vld_ff <= 1'b0;
         t2_vld_ff <= 1'b0;
         t3_vld_ff <= 1'b0;
         t4_vld_ff <= 1'b0;
         t5_vld_ff <= 1'b0;
      end else if (adv) begin
         t1_vld_ff <= cur_vld;
         t2_vld_ff <= t1_vld_ff;
         t3_vld_ff <= t2_vld_ff;
         t4_vld_ff <= t3_vld_ff;
         t5_vld_ff <= t4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_p00_ff  <= 64'(cur_quo[31:0])  * 64'(cur_side_out.flux[31:0]);
         t1_p01_ff  <= 40'(cur_quo[31:0])  * 40'(cur_side_out.flux[39:32]);
         t1_p10_ff  <= 64'(cur_quo[63:32]) * 64'(cur_side_out.flux[31:0]);
         t1_p11_ff  <= 40'(cur_quo[63:32]) * 40'(cur_side_out.flux[39:32]);
         t1_p20_ff  <= 41'(cur_quo[72:64]) * 41'(cur_side_out.flux[31:0]);
         t1_p21_ff  <= 17'(cur_quo[72:64]) * 17'(cur_side_out.flux[39:32]);
         t1_drag_ff <= cur_side_out.drag;
         t1_sneg_ff <= cur_side_out.speed_neg;
         t1_dneg_ff <= cur_side_out.diff_neg;

         t2_r0_ff   <= 72'(t1_p00_ff) + {t1_p01_ff, 32'b0};
         t2_r1_ff   <= 72'(t1_p10_ff) + {t1_p11_ff, 32'b0};
         t2_r2_ff   <= 49'(t1_p20_ff) + {t1_p21_ff, 32'b0};
         t2_drag_ff <= t1_drag_ff;
         t2_sneg_ff <= t1_sneg_ff;
         t2_dneg_ff <= t1_dneg_ff;

         t3_torq_ff <= t3_full_in[112:16];
         t3_drag_ff <= t2_drag_ff;
         t3_sneg_ff <= t2_sneg_ff;
         t3_dneg_ff <= t2_dneg_ff;

         t4_net_ff  <= net_mag_in;
         t4_neg_ff  <= net_sign && (net_mag_in != '0);

         t5_ovf_ff  <= ovf_in;
         t5_neg_ff  <= t4_neg_ff;
         t5_rem_ff  <= ovf_in ? '0 : t4_net_ff[47:16];
         t5_low_ff  <= t4_net_ff[15:0];
      end
   end

   // ---------------- rate = (net << 16) / J ----------------
   rate_side_type     rate_side_in, rate_side_out;
   logic              rate_vld;
   logic [RATE_W-1:0] rate_quo;

   assign rate_side_in = '{overflow: t5_ovf_ff, neg: t5_neg_ff};

   dcfsd_div #(
      .QW (RATE_W),
      .SW ($bits(rate_side_type))
   ) u_rate_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (t5_vld_ff),
      .in_rem    (t5_rem_ff),
      .in_num    ({t5_low_ff, 16'b0}),
      .in_side   (rate_side_in),
      .divisor   (inr_div),
      .out_valid (rate_vld),
      .out_quo   (rate_quo),
      .out_side  (rate_side_out)
   );

   // ---------------- saturation and output register ----------------
   logic              rsp_vld_ff, rsp_sat_ff;
   logic [RATE_W-1:0] rsp_rate_ff;
   logic [RATE_W-1:0] limit, mag;
   logic              sat_in;

   assign limit  = rate_side_out.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
   assign sat_in = rate_side_out.overflow || (rate_quo > limit);
   assign mag    = sat_in ? limit : rate_quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= rate_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_rate_ff <= rate_side_out.neg ? RATE_W'(-mag) : mag;
         rsp_sat_ff  <= sat_in;
      end
   end

   assign adv        = !rsp_vld_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_rate_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule

`default_nettype wire

[rtl/core/dcfsd_div.sv]
// ----------------------------------------------------------------------------
// dcfsd_div
// Pipelined restoring divider, one quotient bit per stage, with side data
// and valid bits travelling alongside. Initial remainder must be below the
// divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module dcfsd_div #(
   parameter int unsigned QW = 32,
   parameter int unsigned SW = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [dcfsd_pkg::DIV_W-1:0] in_rem,
   input  logic [QW-1:0]               in_num,
   input  logic [SW-1:0]               in_side,
   input  logic [dcfsd_pkg::DIV_W-1:0] divisor,
   output logic                        out_valid,
   output logic [QW-1:0]               out_quo,
   output logic [SW-1:0]               out_side
);
   import dcfsd_pkg::*;

   logic              vld_ff  [QW];
   logic [DIV_W-1:0]  rem_ff  [QW];
   logic [QW-1:0]     num_ff  [QW];
   logic [QW-1:0]     quo_ff  [QW];
   logic [SW-1:0]     side_ff [QW];

   for (genvar j = 0; j < QW; j++) begin : g_step
      logic             vld_prev;
      logic [DIV_W-1:0] rem_prev;
      logic [QW-1:0]    num_prev;
      logic [QW-1:0]    quo_prev;
      logic [SW-1:0]    side_prev;
      logic [DIV_W:0]   rem_w;
      logic             ge;
      logic [DIV_W-1:0] rem_in;

      if (j == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = in_rem;
         assign num_prev  = in_num;
         assign quo_prev  = '0;
         assign side_prev = in_side;
      end else begin : g_rest
         assign vld_prev  = vld_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign num_prev  = num_ff[j-1];
         assign quo_prev  = quo_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      assign rem_w  = {rem_prev, num_prev[QW-1]};
      assign ge     = rem_w >= {1'b0, divisor};
      assign rem_in = ge ? DIV_W'(rem_w - {1'b0, divisor}) : rem_w[DIV_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (adv) begin
            vld_ff[j] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j]  <= rem_in;
            num_ff[j]  <= {num_prev[QW-2:0], 1'b0};
            quo_ff[j]  <= {quo_prev[QW-2:0], ge};
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fan motor speed derivative core: directed
// and random voltage/speed beats under several register settings, each
// response checked against a table value or a bit-exact rate predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import dcfsd_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // supply_voltage[31:0], rotor_speed[63:32]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // speed_rate[31:0]
   logic        rsp_tuser;   // saturated
   logic        csr_wen;
   reg_index_type csr_index;
   logic [31:0] csr_wdata;

   dc_motor_fan_speed_derivative_core uut (.*);

   typedef struct {
      logic [31:0] rate;
      logic        sat;
   } rate_beat_type;

   typedef struct {
      logic [31:0] volt;
      logic [31:0] speed;
      bit          typed;   // expected value given below holds under reset settings
      logic [31:0] rate;
      logic        sat;
   } stim_row_type;

   logic [31:0] flux_gain, winding_res, drag_coef, rotor_inertia;
   rate_beat_type pending_rates[$];
   int          errors = 0;
   int          beats_sent = 0;
   int          beats_checked = 0;
   int          sat_seen = 0;
   int          cfg_phases = 0;
   bit          no_stall = 0;
   bit          no_gap = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("tb NOT OK");
      $finish;
   end

   function automatic logic [23:0] root_q16(logic [47:0] v);
      logic [23:0] r;
      logic [23:0] t;
      r = '0;
      for (int b = 23; b >= 0; b--) begin
         t = r | (24'd1 << b);
         if (48'(t) * 48'(t) <= v) r = t;
      end
      return r;
   endfunction

   function automatic rate_beat_type predict_rate(logic [31:0] volt, logic [31:0] speed);
      logic               sneg, diff_neg, tq_neg, drg_neg, net_neg;
      logic [31:0]        spd;
      logic [255:0]       res, inr, flux, emf, diff, cur, tq, sq, drg, mag, q, limit;
      logic signed [255:0] net;
      rate_beat_type      o;
      sneg = speed[31];
      spd  = sneg ? -speed : speed;
      res  = (winding_res == 0) ? 256'd1 : 256'(winding_res);
      inr  = (rotor_inertia == 0) ? 256'd1 : 256'(rotor_inertia);
      flux = (256'(flux_gain) * 256'(root_q16({volt, 16'd0}))) >> 16;
      emf  = (256'(spd) * flux) >> 16;
      if (sneg && emf != 0) begin
         diff = 256'(volt) + emf;
         diff_neg = 0;
      end else if (256'(volt) >= emf) begin
         diff = 256'(volt) - emf;
         diff_neg = 0;
      end else begin
         diff = emf - 256'(volt);
         diff_neg = 1;
      end
      cur = (diff << 16) / res;
      tq  = (cur * flux) >> 16;
      tq_neg = diff_neg && tq != 0;
      sq  = (256'(spd) * 256'(spd)) >> 16;
      drg = (256'(drag_coef) * sq) >> 16;
      drg_neg = sneg && drg != 0;
      net = (tq_neg ? -$signed(tq) : $signed(tq)) - (drg_neg ? -$signed(drg) : $signed(drg));
      net_neg = net < 0;
      mag = net_neg ? -net : net;
      q = (mag << 16) / inr;
      limit = net_neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
      o.sat = q > limit;
      if (o.sat) q = limit;
      o.rate = net_neg ? -q[31:0] : q[31:0];
      return o;
   endfunction

   // leaves the write enable high; the caller drops it after the last write
   task automatic write_reg(reg_index_type idx, logic [31:0] val);
      csr_wen   <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_FLUX_GAIN:     flux_gain     = val;
         REG_WINDING_RES:   winding_res   = val;
         REG_DRAG_COEF:     drag_coef     = val;
         REG_ROTOR_INERTIA: rotor_inertia = val;
      endcase
   endtask

   task automatic set_regs(logic [31:0] fg, logic [31:0] r, logic [31:0] dc, logic [31:0] j);
      req_tvalid <= 0;
      // drain first; every beat yields a response so an empty queue means idle
      while (pending_rates.size() != 0) @(posedge clock);
      write_reg(REG_FLUX_GAIN, fg);
      write_reg(REG_WINDING_RES, r);
      write_reg(REG_DRAG_COEF, dc);
      write_reg(REG_ROTOR_INERTIA, j);
      csr_wen <= 0;
      cfg_phases++;
   endtask

   task automatic send_beat(logic [31:0] volt, logic [31:0] speed, rate_beat_type exp_beat);
      int gap;
      int r;
      req_tvalid <= 1;
      req_tdata  <= {speed, volt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_rates.push_back(exp_beat);
      beats_sent++;
      r = $urandom_range(0, 99);
      gap = no_gap ? 0 : (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] rand_field();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 32'h000F_FFFF);
         3: return -$urandom_range(0, 32'h000F_FFFF);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_reg();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'h1;
         2: return 32'hFFFF_FFFF;
         3: return $urandom;
         default: return $urandom_range(32'h0000_1000, 32'h0004_0000);
      endcase
   endfunction

   // response side backpressure, with occasional long stalls
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset || no_stall) begin
         rsp_tready <= 1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 0;
      end else if ($urandom_range(0, 199) == 0) begin
         stall_left <= $urandom_range(10, 60);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= $urandom_range(0, 99) < 70;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rates.size() == 0) begin
            $error("response beat with nothing expected: rate %h sat %b", rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            rate_beat_type e;
            e = pending_rates.pop_front();
            if (rsp_tdata !== e.rate) begin
               $error("speed_rate: expected %h, got %h", e.rate, rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== e.sat) begin
               $error("saturated: expected %b, got %b", e.sat, rsp_tuser);
               errors++;
            end
            beats_checked++;
            if (rsp_tuser === 1'b1) sat_seen++;
         end
      end
   end

   stim_row_type dir_rows[] = '{
      '{32'h0000_0000, 32'h0000_0000, 1, 32'h0, 1'b0},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1, 32'h0, 1'b0},
      '{32'hFFFF_FFFF, 32'h8000_0000, 1, 32'h0, 1'b0},
      '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 32'h0, 1'b0},
      '{32'h0000_0000, 32'h8000_0000, 1, 32'h0, 1'b0},
      '{32'h0000_0000, 32'hFFFF_FFFF, 1, 32'h0, 1'b0},
      '{32'h0000_0001, 32'h0000_0001, 1, 32'h0, 1'b0},
      '{32'h000C_0000, 32'h0064_0000, 0, 32'h0, 1'b0},
      '{32'h000C_0000, 32'hFF9C_0000, 0, 32'h0, 1'b0},
      '{32'h0018_0000, 32'h0000_0000, 0, 32'h0, 1'b0},
      '{32'h0001_0000, 32'h0200_0000, 0, 32'h0, 1'b0},
      '{32'h8000_0000, 32'hFFFF_0000, 0, 32'h0, 1'b0},
      '{32'h0000_FFFF, 32'h0001_0000, 0, 32'h0, 1'b0}
   };

   task automatic walk_table(bit use_typed);
      rate_beat_type e;
      foreach (dir_rows[i]) begin
         if (use_typed && dir_rows[i].typed) begin
            e.rate = dir_rows[i].rate;
            e.sat  = dir_rows[i].sat;
         end else begin
            e = predict_rate(dir_rows[i].volt, dir_rows[i].speed);
         end
         send_beat(dir_rows[i].volt, dir_rows[i].speed, e);
      end
   endtask

   initial begin
      logic [31:0] v, s;
      int wait_cycles;
      reset      = 1;
      req_tvalid = 0;
      req_tdata  = '0;
      csr_wen    = 0;
      csr_index  = REG_FLUX_GAIN;
      csr_wdata  = '0;
      flux_gain = 0; winding_res = 32'h1_0000; drag_coef = 0; rotor_inertia = 32'h1_0000;
      repeat (4) @(posedge clock);
      reset <= 0;

      // reset settings: flux is zero, so every rate is zero
      walk_table(1);
      // extremes, including zero divisors that act as the smallest value
      set_regs(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
      walk_table(0);
      set_regs(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
      walk_table(0);
      set_regs(32'h0000_8000, 32'h0002_0000, 32'h0000_0010, 32'h0000_8000);
      walk_table(0);

      for (int p = 0; p < 8; p++) begin
         set_regs(rand_reg(), rand_reg(), rand_reg(), rand_reg());
         no_gap   = (p % 3) == 1;
         no_stall = (p % 4) == 2;
         for (int n = 0; n < 160; n++) begin
            v = rand_field();
            s = rand_field();
            send_beat(v, s, predict_rate(v, s));
         end
      end
      req_tvalid <= 0;

      wait_cycles = 0;
      while (pending_rates.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (300) @(posedge clock);
      if (pending_rates.size() != 0) begin
         $error("%0d expected responses never arrived", pending_rates.size());
         errors++;
      end
      $display("%0d beats sent, %0d checked (%0d saturated) over %0d register settings",
               beats_sent, beats_checked, sat_seen, cfg_phases + 1);
      if (errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
